### rtl/itm_pkg.sv
// ============================================================================
// itm_pkg - shared types and constants for the inverter trip monitor
// Trip codes, register indexes and the beat field widths.
// ============================================================================
`default_nettype none

package itm_pkg;

  // Trip codes in priority order
  typedef enum logic [2:0] {
    TRIP_NONE    = 3'd0,
    TRIP_CUR_M   = 3'd1,
    TRIP_CUR_A   = 3'd2,
    TRIP_OVER_V  = 3'd3,
    TRIP_UNDER_V = 3'd4,
    TRIP_HEAT    = 3'd5,
    TRIP_GATE    = 3'd6
  } trip_id_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ENABLE_MASK   = 3'd0,
    CFG_CUR_HIGH      = 3'd1,
    CFG_CUR_LOW       = 3'd2,
    CFG_OVER_VOLT     = 3'd3,
    CFG_UNDER_VOLT    = 3'd4,
    CFG_HEAT_LEVEL    = 3'd5
  } cfg_reg_t;

  // Enable mask bits
  localparam int unsigned EN_CUR   = 0;
  localparam int unsigned EN_OVER  = 1;
  localparam int unsigned EN_UNDER = 2;
  localparam int unsigned EN_HEAT  = 3;

  // Field widths
  localparam int unsigned CUR_W    = 13;
  localparam int unsigned MAG_W    = 14;
  localparam int unsigned VOLT_W   = 14;
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned MASK_W   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned M_DATA_W = 8;

  // Reset values of the configuration registers
  localparam logic [MASK_W-1:0] RST_ENABLE_MASK = 4'd15;
  localparam logic [CUR_W-1:0]  RST_CUR_HIGH    = 13'd3500;
  localparam logic [CUR_W-1:0]  RST_CUR_LOW     = 13'd500;
  localparam logic [VOLT_W-1:0] RST_OVER_VOLT   = 14'd6080;
  localparam logic [VOLT_W-1:0] RST_UNDER_VOLT  = 14'd2880;
  localparam logic [TEMP_W-1:0] RST_HEAT_LEVEL  = 12'd1000;

endpackage

`default_nettype wire

### rtl/inverter_trip_monitor_top.sv
// ============================================================================
// inverter_trip_monitor_top - inverter power stage protection monitor
// One trip code per tick of phase currents, bus voltage, IGBT temperature
// and gate-driver status, checked in strict priority order.
// ============================================================================
// Usage:
//   s_* channel: one beat per control tick carrying both phase currents,
//   the filtered bus voltage, the IGBT temperature reading and gate_ok.
//   m_* channel: one beat per input beat carrying the trip code.
//   cfg_* channel: register writes (index, data); always ready. Write only
//   while no beat is in flight.
// Path: an input beat passes the input register, then the result register,
//   to become the trip code. Throughput: one beat per cycle while m_tready
//   is high; the leaky counters are updated in the same cycle the item moves
//   into the result register, so the next item sees them at once.
// Reset: clears both stages, restores the register defaults and zeroes the
//   over-voltage, under-voltage and heat counters.
// Stall: when m_tready is low the result register holds; the input register
//   still takes one more beat, then s_tready drops until the result moves.
// ============================================================================
`default_nettype none

module inverter_trip_monitor_top
  import itm_pkg::*;
#(
  parameter int unsigned VOLT_TRIP_COUNT = 5,
  parameter int unsigned HEAT_TRIP_COUNT = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // s_tdata: current_m[12:0], current_a[25:13], bus_voltage[39:26],
  //          igbt_temp[51:40], gate_ok[52], zero[55:53]
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [S_DATA_W-1:0]   s_tdata,
  // m_tdata: trip_id[2:0], zero[7:3]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [M_DATA_W-1:0]        m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Counters hold up to limit+2 before the clamp
  localparam int unsigned VCNT_W = $clog2(VOLT_TRIP_COUNT + 3);
  localparam int unsigned HCNT_W = $clog2(HEAT_TRIP_COUNT + 3);
  localparam logic [VCNT_W-1:0] VLIM = VCNT_W'(VOLT_TRIP_COUNT);
  localparam logic [HCNT_W-1:0] HLIM = HCNT_W'(HEAT_TRIP_COUNT);

  // Configuration registers
  logic [MASK_W-1:0] enable_mask;
  logic [CUR_W-1:0]  cur_high;
  logic [CUR_W-1:0]  cur_low;
  logic [VOLT_W-1:0] over_level;
  logic [VOLT_W-1:0] under_level;
  logic [TEMP_W-1:0] heat_level;

  // Input stage
  logic              in_vld;
  logic [CUR_W-1:0]  cur_m;
  logic [CUR_W-1:0]  cur_a;
  logic [VOLT_W-1:0] vbus;
  logic [TEMP_W-1:0] temp;
  logic              gate_ok;

  // Result stage
  logic       out_vld;
  trip_id_t   code;
  trip_id_t   code_next;

  // Leaky counters
  logic [VCNT_W-1:0] ov_cnt, ov_cnt_next;
  logic [VCNT_W-1:0] uv_cnt, uv_cnt_next;
  logic [HCNT_W-1:0] ht_cnt, ht_cnt_next;

  logic adv;

  assign cfg_ready = 1'b1;
  assign adv       = in_vld && (!out_vld || m_tready);
  assign s_tready  = !in_vld || adv;
  assign m_tvalid  = out_vld;
  assign m_tdata   = {(M_DATA_W - 3)'(0), code};

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= RST_ENABLE_MASK;
      cur_high    <= RST_CUR_HIGH;
      cur_low     <= RST_CUR_LOW;
      over_level  <= RST_OVER_VOLT;
      under_level <= RST_UNDER_VOLT;
      heat_level  <= RST_HEAT_LEVEL;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE_MASK: enable_mask <= cfg_data[MASK_W-1:0];
        CFG_CUR_HIGH:    cur_high    <= cfg_data[CUR_W-1:0];
        CFG_CUR_LOW:     cur_low     <= cfg_data[CUR_W-1:0];
        CFG_OVER_VOLT:   over_level  <= cfg_data[VOLT_W-1:0];
        CFG_UNDER_VOLT:  under_level <= cfg_data[VOLT_W-1:0];
        CFG_HEAT_LEVEL:  heat_level  <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: take a beat whenever the stage is empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      cur_m   <= s_tdata[12:0];
      cur_a   <= s_tdata[25:13];
      vbus    <= s_tdata[39:26];
      temp    <= s_tdata[51:40];
      gate_ok <= s_tdata[52];
    end
  end

  // Trip evaluation
  logic [MAG_W-1:0]  mag_m, mag_a;
  logic              trip_m, trip_a, cur_trip;
  logic [VCNT_W-1:0] ov_raw, uv_raw;
  logic [HCNT_W-1:0] ht_raw;
  logic              ov_hit, uv_hit, ht_hit;
  logic              run_ov, run_uv, run_ht;

  always_comb begin
    // Full-width magnitude, so the most negative sample gives 4096
    mag_m = cur_m[CUR_W-1] ? MAG_W'(0) - {cur_m[CUR_W-1], cur_m} : {1'b0, cur_m};
    mag_a = cur_a[CUR_W-1] ? MAG_W'(0) - {cur_a[CUR_W-1], cur_a} : {1'b0, cur_a};
    trip_m = enable_mask[EN_CUR] &&
             (mag_m > {1'b0, cur_high} || mag_m < {1'b0, cur_low});
    trip_a = enable_mask[EN_CUR] &&
             (mag_a > {1'b0, cur_high} || mag_a < {1'b0, cur_low});
    cur_trip = trip_m || trip_a;

    // Over-voltage runs only if the current window passed
    if (vbus > over_level) ov_raw = ov_cnt + VCNT_W'(1);
    else if (ov_cnt != '0) ov_raw = ov_cnt - VCNT_W'(1);
    else                   ov_raw = ov_cnt;
    run_ov = enable_mask[EN_OVER] && !cur_trip;
    ov_hit = run_ov && (ov_raw > VLIM);

    if (vbus < under_level) uv_raw = uv_cnt + VCNT_W'(1);
    else if (uv_cnt != '0)  uv_raw = uv_cnt - VCNT_W'(1);
    else                    uv_raw = uv_cnt;
    run_uv = enable_mask[EN_UNDER] && !cur_trip && !ov_hit;
    uv_hit = run_uv && (uv_raw > VLIM);

    if (temp < heat_level) ht_raw = ht_cnt + HCNT_W'(1);
    else if (ht_cnt != '0) ht_raw = ht_cnt - HCNT_W'(1);
    else                   ht_raw = ht_cnt;
    run_ht = enable_mask[EN_HEAT] && !cur_trip && !ov_hit && !uv_hit;
    ht_hit = run_ht && (ht_raw > HLIM);

    // Disabled or skipped checks hold their counters; a trip clamps
    ov_cnt_next = ov_cnt;
    if (run_ov) ov_cnt_next = (ov_raw > VLIM) ? VLIM + VCNT_W'(1) : ov_raw;
    uv_cnt_next = uv_cnt;
    if (run_uv) uv_cnt_next = (uv_raw > VLIM) ? VLIM + VCNT_W'(1) : uv_raw;
    ht_cnt_next = ht_cnt;
    if (run_ht) ht_cnt_next = (ht_raw > HLIM) ? HLIM + HCNT_W'(1) : ht_raw;

    if (trip_m)        code_next = TRIP_CUR_M;
    else if (trip_a)   code_next = TRIP_CUR_A;
    else if (ov_hit)   code_next = TRIP_OVER_V;
    else if (uv_hit)   code_next = TRIP_UNDER_V;
    else if (ht_hit)   code_next = TRIP_HEAT;
    else if (!gate_ok) code_next = TRIP_GATE;
    else               code_next = TRIP_NONE;
  end

  // Result register and counters advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      ov_cnt  <= '0;
      uv_cnt  <= '0;
      ht_cnt  <= '0;
    end else begin
      if (adv) begin
        out_vld <= 1'b1;
        ov_cnt  <= ov_cnt_next;
        uv_cnt  <= uv_cnt_next;
        ht_cnt  <= ht_cnt_next;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code <= code_next;
    end
  end

endmodule

`default_nettype wire

### rtl/itm_checker.sv
// ============================================================================
// itm_checker - port-level checks for the inverter trip monitor
// Watches the stream ports and flags illegal result beats and lost items.
// ============================================================================
`default_nettype none

module itm_checker
  import itm_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata
);

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Only defined trip codes, padding zero
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_DATA_W-1:3] == '0) && (m_tdata[2:0] != 3'd7))
    else $error("illegal trip code");

  // An accepted beat shows up as a result after the input and result registers
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ##1 m_tvalid)
    else $error("accepted beat produced no result");

  // Nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind inverter_trip_monitor_top itm_checker u_itm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/inverter_trip_monitor_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// inverter_trip_monitor_top_tb - self-checking bench for the trip monitor
// Streams sample beats through the monitor under several register settings
// and handshake pressure patterns. A local copy of the priority checks and
// leaky counters predicts each trip code; the output monitor compares every
// result beat against the oldest prediction.
// ============================================================================

module inverter_trip_monitor_top_tb;
  import itm_pkg::*;

  // Trip limits of the leaky counters (block defaults)
  localparam int unsigned VOLT_LIMIT = 5;
  localparam int unsigned HEAT_LIMIT = 10;
  localparam int unsigned CUR_MAX    = 4096;
  localparam int unsigned VOLT_MAX   = 16383;
  localparam int unsigned TEMP_MAX   = 4095;
  localparam int unsigned RUN_BEATS  = 52;

  // One sample beat, first field in the lowest bits
  typedef struct packed {
    logic [2:0]        pad;
    logic              gate_ok;
    logic [11:0]       igbt_temp;
    logic [13:0]       bus_voltage;
    logic signed [12:0] current_a;
    logic signed [12:0] current_m;
  } tick_t;

  // Shapes of stimulus runs
  typedef enum int {
    RUN_CALM, RUN_OVER, RUN_UNDER, RUN_HOT, RUN_GATE, RUN_CURRENT, RUN_NOISE
  } run_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  inverter_trip_monitor_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // current_m, current_a, bus_voltage, igbt_temp, gate_ok
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // trip_id
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the register file and counters
  logic [MASK_W-1:0] en_mask  = RST_ENABLE_MASK;
  logic [12:0]       cur_hi   = RST_CUR_HIGH;
  logic [12:0]       cur_lo   = RST_CUR_LOW;
  logic [13:0]       ov_lvl   = RST_OVER_VOLT;
  logic [13:0]       uv_lvl   = RST_UNDER_VOLT;
  logic [11:0]       heat_lvl = RST_HEAT_LEVEL;
  int unsigned       ov_count   = 0;
  int unsigned       uv_count   = 0;
  int unsigned       heat_count = 0;

  tick_t      tick_q[$];   // beats waiting for the driver
  trip_id_t   trip_q[$];   // predicted trip codes, oldest first
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       s_taken = 1'b0;
  logic       cfg_took = 1'b0;

  // Free-running clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the pipeline locks up
  initial begin
    #2_000_000;
    $display("inverter_trip_monitor_top_tb: errors");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned current_mag(logic signed [12:0] v);
    return (v < 0) ? int'(-int'(v)) : int'(v);
  endfunction

  function automatic bit out_of_window(int unsigned mag);
    return (mag > cur_hi) || (mag < cur_lo);
  endfunction

  // Leak down when quiet, count up when the condition holds, clamp past limit
  function automatic int unsigned leaky_next(int unsigned cnt, bit cond,
                                             int unsigned limit);
    int unsigned nxt;
    nxt = cond ? cnt + 1 : ((cnt > 0) ? cnt - 1 : 0);
    return (nxt > limit) ? limit + 1 : nxt;
  endfunction

  // Run the checks in priority order; the first trip stops the rest
  function automatic trip_id_t judge_tick(tick_t t);
    trip_id_t code;
    code = TRIP_NONE;
    if (en_mask[EN_CUR] && out_of_window(current_mag(t.current_m))) begin
      code = TRIP_CUR_M;
    end else if (en_mask[EN_CUR] && out_of_window(current_mag(t.current_a))) begin
      code = TRIP_CUR_A;
    end
    if (code == TRIP_NONE && en_mask[EN_OVER]) begin
      ov_count = leaky_next(ov_count, t.bus_voltage > ov_lvl, VOLT_LIMIT);
      if (ov_count > VOLT_LIMIT) code = TRIP_OVER_V;
    end
    if (code == TRIP_NONE && en_mask[EN_UNDER]) begin
      uv_count = leaky_next(uv_count, t.bus_voltage < uv_lvl, VOLT_LIMIT);
      if (uv_count > VOLT_LIMIT) code = TRIP_UNDER_V;
    end
    if (code == TRIP_NONE && en_mask[EN_HEAT]) begin
      heat_count = leaky_next(heat_count, t.igbt_temp < heat_lvl, HEAT_LIMIT);
      if (heat_count > HEAT_LIMIT) code = TRIP_HEAT;
    end
    if (code == TRIP_NONE && !t.gate_ok) code = TRIP_GATE;
    return code;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present beats and the ready at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    // Hold a beat until it is taken; otherwise advance or idle
    if (!s_tvalid || s_taken) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= tick_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample handshakes at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    trip_id_t got;
    s_taken  <= s_tvalid && s_tready;
    cfg_took <= cfg_valid && cfg_ready;
    if (!rst) begin
      // Track register writes so predictions use the live settings
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ENABLE_MASK: en_mask  = cfg_data[MASK_W-1:0];
          CFG_CUR_HIGH:    cur_hi   = cfg_data[12:0];
          CFG_CUR_LOW:     cur_lo   = cfg_data[12:0];
          CFG_OVER_VOLT:   ov_lvl   = cfg_data[13:0];
          CFG_UNDER_VOLT:  uv_lvl   = cfg_data[13:0];
          CFG_HEAT_LEVEL:  heat_lvl = cfg_data[11:0];
          default: ;
        endcase
      end
      // Predict on every accepted sample beat
      if (s_tvalid && s_tready) trip_q.push_back(judge_tick(tick_t'(s_tdata)));
      // Compare every accepted result beat against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = trip_id_t'(m_tdata[2:0]);
        if (trip_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected trip code %0d", got));
        end else if (got !== trip_q[0]) begin
          flag_mismatch($sformatf("trip code got %0d want %0d", got, trip_q[0]));
          void'(trip_q.pop_front());
        end else begin
          void'(trip_q.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic bit in_flight();
    return tick_q.size() != 0 || s_tvalid || trip_q.size() != 0;
  endfunction

  function automatic int unsigned pick_range(int unsigned lo, int unsigned hi);
    return (lo > hi) ? hi : $urandom_range(hi, lo);
  endfunction

  // A current whose magnitude sits inside the window when the window exists
  function automatic logic signed [12:0] calm_current();
    int unsigned mag;
    int          val;
    mag = (cur_lo <= cur_hi) ? pick_range(cur_lo, (cur_hi > CUR_MAX) ? CUR_MAX : cur_hi)
                             : $urandom_range(CUR_MAX);
    val = (mag == CUR_MAX || $urandom_range(1)) ? -int'(mag) : int'(mag);
    return 13'(val);
  endfunction

  function automatic tick_t make_tick(run_kind_t kind);
    tick_t t;
    t.pad         = '0;
    t.current_m   = calm_current();
    t.current_a   = calm_current();
    t.bus_voltage = (uv_lvl <= ov_lvl) ? 14'(pick_range(uv_lvl, ov_lvl))
                                       : 14'($urandom_range(VOLT_MAX));
    t.igbt_temp   = 12'(pick_range(heat_lvl, TEMP_MAX));
    t.gate_ok     = ($urandom_range(9) != 0);
    case (kind)
      RUN_OVER:  t.bus_voltage = 14'(pick_range(ov_lvl + 1, VOLT_MAX));
      RUN_UNDER: t.bus_voltage = (uv_lvl == 0) ? '0 : 14'($urandom_range(uv_lvl - 1));
      RUN_HOT:   t.igbt_temp = (heat_lvl == 0) ? '0 : 12'($urandom_range(heat_lvl - 1));
      RUN_GATE:  t.gate_ok = 1'b0;
      RUN_CURRENT: begin
        if ($urandom_range(1)) t.current_m = 13'($urandom);
        else                   t.current_a = 13'($urandom);
      end
      RUN_NOISE: t = tick_t'({3'b000, 21'($urandom), 32'($urandom)});
      default: ;
    endcase
    return t;
  endfunction

  task automatic queue_tick(input int cm, input int ca, input int vbus,
                            input int temp, input bit gate);
    tick_t t;
    t = '{pad: 3'b000, gate_ok: gate, igbt_temp: 12'(temp), bus_voltage: 14'(vbus),
          current_a: 13'(ca), current_m: 13'(cm)};
    tick_q.push_back(t);
  endtask

  // Mostly well-formed runs of one condition, with some pure noise mixed in
  task automatic queue_runs(input int unsigned beats);
    int unsigned queued;
    int unsigned run_len;
    run_kind_t   kind;
    queued = 0;
    while (queued < beats) begin
      kind = run_kind_t'($urandom_range(RUN_NOISE));
      run_len = (kind inside {RUN_OVER, RUN_UNDER, RUN_HOT}) ? $urandom_range(16, 3)
                                                             : $urandom_range(6, 1);
      repeat (run_len) begin
        tick_q.push_back(make_tick(kind));
        queued++;
      end
    end
  endtask

  // One register write; starts and ends on a falling edge
  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 14'(value);
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input int unsigned mask, input int unsigned hi,
                               input int unsigned lo, input int unsigned ov,
                               input int unsigned uv, input int unsigned heat);
    write_reg(CFG_ENABLE_MASK, mask);
    write_reg(CFG_CUR_HIGH, hi);
    write_reg(CFG_CUR_LOW, lo);
    write_reg(CFG_OVER_VOLT, ov);
    write_reg(CFG_UNDER_VOLT, uv);
    write_reg(CFG_HEAT_LEVEL, heat);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Hold reset, then release it on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      // Drain before touching the registers
      while (in_flight()) @(posedge clk);
      case (ph)
        0: ;  // run on the reset defaults
        // Nothing enabled, widest window, unreachable levels
        1: load_settings(0, CUR_MAX, 0, VOLT_MAX, 0, 0);
        // Current check off, swapped limits; every voltage but the rails counts both ways, all but full scale hot
        2: load_settings(4'b1110, 0, CUR_MAX, 0, VOLT_MAX, TEMP_MAX);
        // Back to the reset values
        7: load_settings(RST_ENABLE_MASK, RST_CUR_HIGH, RST_CUR_LOW,
                         RST_OVER_VOLT, RST_UNDER_VOLT, RST_HEAT_LEVEL);
        default: begin
          load_settings($urandom_range(3) == 0 ? $urandom_range(15) : 15,
                        $urandom_range(CUR_MAX, 2500), $urandom_range(1500),
                        $urandom_range(VOLT_MAX), $urandom_range(VOLT_MAX),
                        $urandom_range(TEMP_MAX));
        end
      endcase

      // Rotate the pressure pattern: none, sender gaps, receiver stalls, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase

      if (ph == 0) begin
        // Nominal tick, then the gate fault alone
        queue_tick(1000, -1000, 4000, 2000, 1'b1);
        queue_tick(1000, -1000, 4000, 2000, 1'b0);
        // Current extremes on each phase; full-scale negative has magnitude 4096
        queue_tick(-4096, 1000, 4000, 2000, 1'b1);
        queue_tick(4095, 1000, 4000, 2000, 1'b1);
        queue_tick(0, 1000, 4000, 2000, 1'b1);
        queue_tick(1000, -4096, 4000, 2000, 1'b1);
        queue_tick(1000, 0, 4000, 2000, 1'b1);
        // Both window edges exactly, which do not trip
        queue_tick(3500, -500, 4000, 2000, 1'b1);
        // Full-scale bus: counter trips on the sixth beat
        repeat (6) queue_tick(1000, 1000, VOLT_MAX, TEMP_MAX, 1'b1);
        // Zero bus and hottest reading: over-voltage leaks down, under-voltage
        // climbs to a trip while heat counts underneath the gate fault
        repeat (6) queue_tick(1000, 1000, 0, 0, 1'b0);
        queue_tick(-1, 1, 6081, 999, 1'b1);
      end
      queue_runs(RUN_BEATS);
    end

    // Drain, then give the two-stage pipe time to show any stray beat
    while (in_flight()) @(posedge clk);
    repeat (4) @(posedge clk);
    if (trip_q.size() != 0) flag_mismatch("predicted trip codes left over");

    if (mismatches == 0) begin
      $display("inverter_trip_monitor_top_tb: clean");
    end else begin
      $display("inverter_trip_monitor_top_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/itm_pkg.sv
rtl/inverter_trip_monitor_top.sv
rtl/itm_checker.sv
tb/inverter_trip_monitor_top_tb.sv
